FILE: hdl/rgba_area_rescaler_core_defines.svh
// Assertion macros for the RGBA area rescaler.
// Depends on nothing; the using module must have clk and arst_n in scope.
`ifndef RGBA_AREA_RESCALER_CORE_DEFINES_SVH
`define RGBA_AREA_RESCALER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RAR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define RAR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/rar_pkg.sv
// Types, codes and constants shared by the RGBA area rescaler.
// No dependencies.
`timescale 1ns / 1ps

package rar_pkg;

	// command codes
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_FETCH   = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SCALE      = 2'd2;

	// reset values
	localparam logic [6:0]  RST_SRC_WIDTH  = 7'd32;
	localparam logic [6:0]  RST_SRC_HEIGHT = 7'd32;
	localparam logic [12:0] RST_SCALE      = 13'd100;

	// percent unit and reciprocal of 100 (2^27 / 100, rounded down)
	localparam logic [6:0]  PCT       = 7'd100;
	localparam logic [20:0] DIV_RECIP = 21'd1342177;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
		logic       pixel_valid;
		logic       last_pixel;
		logic       size_error;
	} result_t;

	// output row store controls
	typedef struct packed {
		logic clr;
		logic we;
		logic re;
	} row_ctl_t;

	// floor(x / 100): reciprocal estimate is exact or one low, one correction step
	function automatic logic [20:0] div100(input logic [20:0] x);
		logic [41:0] p;
		logic [20:0] q;
		logic [27:0] r;
		p = {21'd0, x} * {21'd0, DIV_RECIP};
		q = {6'd0, p[41:27]};
		r = {7'd0, x} - (28'(q) * 28'(PCT));
		if (r >= 28'(PCT)) q = q + 21'd1;
		return q;
	endfunction

endpackage

FILE: hdl/rar_row_store.sv
// Output row store: one scaled row, synchronous read, per-entry valid bits.
// Depends on rar_pkg. Entries not written since the last clear read as zero.
`timescale 1ns / 1ps

module rar_row_store
	import rar_pkg::*;
#(
	parameter int MAX_WIDTH = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  row_ctl_t                                ctl,
	input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] waddr,
	input  logic [31:0]                             wdata,
	input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] raddr,
	output logic [31:0]                             rdata
);

	logic [31:0]          mem [MAX_WIDTH];
	logic [MAX_WIDTH-1:0] vld_q;
	logic [31:0]          rd_q;
	logic                 hit_q;

	// valid bits: cleared per row, set on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (ctl.re) begin
				hit_q <= vld_q[raddr];
			end
		end
	end

	// storage array
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
		if (ctl.re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = hit_q ? rd_q : 32'd0;

endmodule

FILE: hdl/rgba_area_rescaler_core.sv
// Top level of the RGBA area rescaler: frame store, row builder and fetch control.
// Depends on rar_pkg, rar_row_store and rgba_area_rescaler_core_defines.svh.
//
//  channel   | handshake                 | word
//  ----------+---------------------------+------------------------------
//  command   | start, busy               | item (item_t)
//  result    | done (one-cycle strobe)   | result (result_t)
//  config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// Load, restart and unknown commands are handled in S_IDLE; busy stays low.
// A fetch within a built row passes S_SIZE_MUL, S_SIZE_DIV, S_DECIDE, S_READ, S_OUT before done.
// Opening a row adds S_B_INIT, S_H_TAIL, S_H_TADD, S_B_END; per column S_B_COL, per
// source row read, multiply and accumulate, and per horizontal term S_H_CHK, S_H_ADD.
// Reset clears all control state; the frame store needs no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle.
`timescale 1ns / 1ps
`include "rgba_area_rescaler_core_defines.svh"

module rgba_area_rescaler_core
	import rar_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int FAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LPW   = $clog2(DEPTH + 1);
	localparam int CIW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int XW    = $clog2(MAX_WIDTH + 1);
	localparam int YW    = $clog2(MAX_HEIGHT + 1);
	localparam int DW    = $clog2(MAX_WIDTH) + 8;

	typedef enum logic [4:0] {
		S_IDLE, S_SIZE_MUL, S_SIZE_DIV, S_DECIDE,
		S_B_INIT, S_B_COL, S_V_CHK, S_V_MUL, S_V_ACC,
		S_H_CHK, S_H_ADD, S_H_TAIL, S_H_TADD, S_B_END,
		S_READ, S_OUT
	} state_t;

	state_t state_q;

	// configuration and image position
	logic [6:0]     w_q, h_q;
	logic [12:0]    sc_q;
	logic [LPW-1:0] lp_q;
	logic [6:0]     sr_q;
	logic [12:0]    rl_q;
	logic [XW-1:0]  ocol_q;
	logic [YW-1:0]  orow_q;
	logic           done_q;
	result_t        result_q;

	// sizes
	logic [19:0] pw_s1, ph_s1;
	logic [14:0] nw_q, nh_q;

	// vertical walk
	logic [FAW-1:0] sr0w_q, vaddr_q;
	logic [XW-1:0]  x_q;
	logic [12:0]    vrl_q;
	logic [6:0]     vrf_q;
	logic [6:0]     vsr_q;
	logic           fin_q;
	logic [9:0]     acc_r_q, acc_g_q, acc_b_q;
	logic [9:0]     bl_r_q, bl_g_q, bl_b_q;
	logic [7:0]     bl_a_q;
	logic [20:0]    prod_r_s1, prod_g_s1, prod_b_s1;
	logic [7:0]     pa_s1;
	logic [31:0]    fs_rd_q;

	// horizontal walk
	logic [12:0]   leftx_q;
	logic [6:0]    fillx_q;
	logic          need_q, modea_q;
	logic [DW-1:0] dest_q;
	logic [7:0]    hr_q, hg_q, hb_q, ha_q;

	logic [31:0] fs_mem [DEPTH];

	logic        accept, fs_we, fs_re;
	logic [6:0]  last_row;
	logic [20:0] div_r, div_g, div_b;
	logic [7:0]  hr_n, hg_n, hb_n, ha_n;
	logic        dest_fits;
	logic        over, empty, adv;
	logic [XW-1:0] col_d;
	logic [YW-1:0] row_d;
	logic [12:0] rl_diff;
	result_t     err_word;
	row_ctl_t    rctl;
	logic [31:0] row_rdata;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;
	assign last_row  = h_q - 7'd1;

	// shared divide-by-100 on the product registers
	assign div_r = div100(prod_r_s1);
	assign div_g = div100(prod_g_s1);
	assign div_b = div100(prod_b_s1);

	// horizontal accumulate, colour wraps at 8 bits
	always_comb begin
		hr_n = hr_q;
		hg_n = hg_q;
		hb_n = hb_q;
		if (bl_a_q != 8'd0) begin
			hr_n = hr_q + div_r[7:0];
			hg_n = hg_q + div_g[7:0];
			hb_n = hb_q + div_b[7:0];
		end
		ha_n = (bl_a_q > ha_q) ? bl_a_q : ha_q;
	end

	assign dest_fits = (int'(dest_q) < int'(nw_q)) && (int'(dest_q) < MAX_WIDTH);

	// fetch decision
	always_comb begin
		over = (int'(w_q) > MAX_WIDTH) || (int'(nw_q) > MAX_WIDTH)
			|| (int'(h_q) > MAX_HEIGHT) || (int'(nh_q) > MAX_HEIGHT);
		empty = (nw_q == 15'd0) || (nh_q == 15'd0);
		adv   = (int'(ocol_q) >= int'(nw_q)) && (int'(orow_q) < int'(nh_q));
		col_d = adv ? '0 : ocol_q;
		row_d = adv ? (orow_q + YW'(1)) : orow_q;
		err_word = '0;
		err_word.size_error = 1'b1;
	end

	assign rl_diff = vrl_q - 13'(vrf_q);

	// row store controls
	always_comb begin
		rctl.clr = (state_q == S_B_INIT);
		rctl.we  = ((state_q == S_H_ADD) && modea_q && dest_fits)
			|| ((state_q == S_H_TADD) && !need_q && dest_fits);
		rctl.re  = (state_q == S_READ);
	end

	assign fs_we = accept && (item.cmd == CMD_LOAD) && (int'(lp_q) < DEPTH);
	assign fs_re = (state_q == S_V_CHK);

	// frame store
	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[lp_q[FAW-1:0]] <= {item.alpha, item.blue, item.green, item.red};
		end
		if (fs_re) begin
			fs_rd_q <= fs_mem[vaddr_q];
		end
	end

	// control state machine and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			w_q      <= RST_SRC_WIDTH;
			h_q      <= RST_SRC_HEIGHT;
			sc_q     <= RST_SCALE;
			lp_q     <= '0;
			sr_q     <= '0;
			rl_q     <= RST_SCALE;
			ocol_q   <= '0;
			orow_q   <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SRC_WIDTH:  w_q  <= cfg_data[6:0];
					REG_SRC_HEIGHT: h_q  <= cfg_data[6:0];
					REG_SCALE:      sc_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.cmd)
							CMD_LOAD: begin
								if (fs_we) lp_q <= lp_q + LPW'(1);
							end
							CMD_FETCH: state_q <= S_SIZE_MUL;
							CMD_RESTART: begin
								lp_q   <= '0;
								sr_q   <= '0;
								ocol_q <= '0;
								orow_q <= '0;
								rl_q   <= sc_q;
							end
							default: ;
						endcase
					end
				end
				S_SIZE_MUL: state_q <= S_SIZE_DIV;
				S_SIZE_DIV: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (over) begin
						result_q <= err_word;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (empty) begin
						result_q <= '0;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						ocol_q <= col_d;
						orow_q <= row_d;
						if (int'(row_d) >= int'(nh_q)) begin
							result_q <= '0;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else if (col_d == '0) begin
							state_q <= S_B_INIT;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_B_INIT: state_q <= S_B_COL;
				S_B_COL:  state_q <= S_V_CHK;
				S_V_CHK:  state_q <= S_V_MUL;
				S_V_MUL:  state_q <= S_V_ACC;
				S_V_ACC:  state_q <= fin_q ? S_H_CHK : S_V_CHK;
				S_H_CHK: begin
					if ((leftx_q >= 13'(fillx_q)) || (leftx_q != 13'd0)) begin
						state_q <= S_H_ADD;
					end else if ((int'(x_q) + 1) < int'(w_q)) begin
						state_q <= S_B_COL;
					end else begin
						state_q <= S_H_TAIL;
					end
				end
				S_H_ADD:  state_q <= S_H_CHK;
				S_H_TAIL: state_q <= S_H_TADD;
				S_H_TADD: state_q <= S_B_END;
				S_B_END: begin
					// carry the row weight into the next output row
					if (rl_diff == 13'd0) begin
						rl_q <= sc_q;
						sr_q <= (vsr_q < last_row) ? (vsr_q + 7'd1) : vsr_q;
					end else begin
						rl_q <= rl_diff;
						sr_q <= vsr_q;
					end
					state_q <= S_READ;
				end
				S_READ: state_q <= S_OUT;
				S_OUT: begin
					result_q.out_red     <= row_rdata[7:0];
					result_q.out_green   <= row_rdata[15:8];
					result_q.out_blue    <= row_rdata[23:16];
					result_q.out_alpha   <= row_rdata[31:24];
					result_q.pixel_valid <= 1'b1;
					result_q.size_error  <= 1'b0;
					result_q.last_pixel  <= ((int'(orow_q) + 1) == int'(nh_q))
						&& ((int'(ocol_q) + 1) == int'(nw_q));
					done_q <= 1'b1;
					if ((int'(ocol_q) + 1) >= int'(nw_q)) begin
						ocol_q <= '0;
						orow_q <= orow_q + YW'(1);
					end else begin
						ocol_q <= ocol_q + XW'(1);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// row builder datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_SIZE_MUL: begin
				pw_s1 <= 20'(w_q) * 20'(sc_q);
				ph_s1 <= 20'(h_q) * 20'(sc_q);
			end
			S_SIZE_DIV: begin
				nw_q <= 15'(div100({1'b0, pw_s1}));
				nh_q <= 15'(div100({1'b0, ph_s1}));
			end
			S_B_INIT: begin
				sr0w_q  <= FAW'(14'(sr_q) * 14'(w_q));
				x_q     <= '0;
				fillx_q <= PCT;
				need_q  <= 1'b0;
				dest_q  <= '0;
				hr_q    <= '0;
				hg_q    <= '0;
				hb_q    <= '0;
				ha_q    <= '0;
			end
			S_B_COL: begin
				vrl_q   <= rl_q;
				vrf_q   <= PCT;
				vsr_q   <= sr_q;
				vaddr_q <= sr0w_q + FAW'(x_q);
				acc_r_q <= '0;
				acc_g_q <= '0;
				acc_b_q <= '0;
			end
			S_V_CHK: begin
				// last term of the column once the row weight covers the rest
				fin_q <= !(vrl_q < 13'(vrf_q));
			end
			S_V_MUL: begin
				if (fin_q) begin
					prod_r_s1 <= 21'(vrf_q) * 21'(fs_rd_q[7:0]);
					prod_g_s1 <= 21'(vrf_q) * 21'(fs_rd_q[15:8]);
					prod_b_s1 <= 21'(vrf_q) * 21'(fs_rd_q[23:16]);
				end else begin
					prod_r_s1 <= 21'(vrl_q) * 21'(fs_rd_q[7:0]);
					prod_g_s1 <= 21'(vrl_q) * 21'(fs_rd_q[15:8]);
					prod_b_s1 <= 21'(vrl_q) * 21'(fs_rd_q[23:16]);
				end
				pa_s1 <= fs_rd_q[31:24];
			end
			S_V_ACC: begin
				if (fin_q) begin
					// transparent final row drops the whole column colour
					if (pa_s1 != 8'd0) begin
						bl_r_q <= acc_r_q + div_r[9:0];
						bl_g_q <= acc_g_q + div_g[9:0];
						bl_b_q <= acc_b_q + div_b[9:0];
					end else begin
						bl_r_q <= '0;
						bl_g_q <= '0;
						bl_b_q <= '0;
					end
					bl_a_q  <= pa_s1;
					leftx_q <= sc_q;
				end else begin
					if (pa_s1 != 8'd0) begin
						acc_r_q <= acc_r_q + div_r[9:0];
						acc_g_q <= acc_g_q + div_g[9:0];
						acc_b_q <= acc_b_q + div_b[9:0];
					end
					vrf_q <= vrf_q - vrl_q[6:0];
					vrl_q <= sc_q;
					if (vsr_q < last_row) begin
						vsr_q   <= vsr_q + 7'd1;
						vaddr_q <= vaddr_q + FAW'(w_q);
					end
				end
			end
			S_H_CHK: begin
				if (leftx_q >= 13'(fillx_q)) begin
					// term closes an output pixel
					modea_q   <= 1'b1;
					prod_r_s1 <= 21'(fillx_q) * 21'(bl_r_q);
					prod_g_s1 <= 21'(fillx_q) * 21'(bl_g_q);
					prod_b_s1 <= 21'(fillx_q) * 21'(bl_b_q);
					if (need_q) begin
						dest_q <= dest_q + DW'(1);
						hr_q <= '0; hg_q <= '0; hb_q <= '0; ha_q <= '0;
					end
					leftx_q <= leftx_q - 13'(fillx_q);
					fillx_q <= PCT;
					need_q  <= 1'b1;
				end else if (leftx_q != 13'd0) begin
					// partial term carried into the next pixel
					modea_q   <= 1'b0;
					prod_r_s1 <= 21'(leftx_q[6:0]) * 21'(bl_r_q);
					prod_g_s1 <= 21'(leftx_q[6:0]) * 21'(bl_g_q);
					prod_b_s1 <= 21'(leftx_q[6:0]) * 21'(bl_b_q);
					if (need_q) begin
						dest_q <= dest_q + DW'(1);
						hr_q <= '0; hg_q <= '0; hb_q <= '0; ha_q <= '0;
						need_q <= 1'b0;
					end
					fillx_q <= fillx_q - leftx_q[6:0];
					leftx_q <= '0;
				end else begin
					x_q <= x_q + XW'(1);
				end
			end
			S_H_ADD, S_H_TADD: begin
				hr_q <= hr_n;
				hg_q <= hg_n;
				hb_q <= hb_n;
				ha_q <= ha_n;
			end
			S_H_TAIL: begin
				// remaining fill weight taken from the last column
				prod_r_s1 <= 21'(fillx_q) * 21'(bl_r_q);
				prod_g_s1 <= 21'(fillx_q) * 21'(bl_g_q);
				prod_b_s1 <= 21'(fillx_q) * 21'(bl_b_q);
			end
			default: ;
		endcase
	end

	rar_row_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_row (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.waddr  (dest_q[CIW-1:0]),
		.wdata  ({ha_n, hb_n, hg_n, hr_n}),
		.raddr  (ocol_q[CIW-1:0]),
		.rdata  (row_rdata)
	);

	`RAR_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
	`RAR_ASSERT_NEXT(a_fetch_busy, start && !busy && item.cmd == CMD_FETCH, busy, "fetch not taken")
	`RAR_ASSERT_NOW(a_err_nopix, done && result.size_error, !result.pixel_valid, "pixel with error")
	`RAR_ASSERT_NOW(a_last_valid, done && result.last_pixel, result.pixel_valid, "last without pixel")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for rgba_area_rescaler_core: loads images, fetches scaled pixels.
// Predicts each fetched pixel with its own area-scaling model.
// Depends on rar_pkg and rgba_area_rescaler_core.
`timescale 1ns / 1ps

module testbench;
	import rar_pkg::*;

	localparam logic [1:0] CMD_IGNORED = 2'd3;
	localparam int unsigned MAXW = 64;
	localparam int unsigned MAXH = 64;
	localparam int unsigned STORE_DEPTH = MAXW * MAXH;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item = '0;
	logic        done;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;

	rgba_area_rescaler_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// pending command words and expected pixels
	item_t   cmd_queue[$];
	result_t expected_pixels[$];
	int      errors = 0;
	int      pixels_checked = 0;
	int      words_sent = 0;
	int      images = 0;

	// scaler state mirror
	logic [31:0] frame[STORE_DEPTH];
	int unsigned vsum[MAXW][4];
	int unsigned blend[MAXW][4];
	logic [31:0] out_line[MAXW];
	int unsigned load_ptr, src_row, out_row, out_col;
	int          rows_left, rows_fill;
	int unsigned width_reg, height_reg, scale_reg;
	int unsigned acc_r, acc_g, acc_b, acc_a;

	function automatic int unsigned src_chan(int unsigned row, int unsigned col, int c);
		int unsigned idx;
		idx = row * width_reg + col;
		if (idx >= STORE_DEPTH) return 0;
		return (frame[idx] >> (8 * c)) & 32'hFF;
	endfunction

	task automatic add_column(int unsigned col, int unsigned wt);
		if (blend[col][3] > 0) begin
			acc_r = (acc_r + wt * blend[col][0] / 100) & 32'hFF;
			acc_g = (acc_g + wt * blend[col][1] / 100) & 32'hFF;
			acc_b = (acc_b + wt * blend[col][2] / 100) & 32'hFF;
		end
		if (blend[col][3] > acc_a) acc_a = blend[col][3];
	endtask

	task automatic put_column(int unsigned dest, int unsigned nw);
		if (dest < nw && dest < MAXW)
			out_line[dest] = acc_r | (acc_g << 8) | (acc_b << 16) | (acc_a << 24);
	endtask

	// vertical blend of source rows, then horizontal blend into out_line
	task automatic build_line(int unsigned w, int unsigned h, int unsigned nw);
		int unsigned sr, last, a, fillx, dest, leftx;
		int scale;
		bit need;
		sr = src_row;
		last = h - 1;
		scale = int'(scale_reg);
		fillx = 100;
		dest = 0;
		need = 0;
		for (int x = 0; x < MAXW; x++) begin
			out_line[x] = '0;
			for (int c = 0; c < 4; c++) blend[x][c] = 0;
		end
		rows_fill = 100;
		while (rows_left < rows_fill) begin
			for (int unsigned x = 0; x < w; x++) begin
				a = src_chan(sr, x, 3);
				if (a > 0)
					for (int c = 0; c < 3; c++)
						vsum[x][c] += int'(rows_left) * src_chan(sr, x, c) / 100;
				if (a > vsum[x][3]) vsum[x][3] = a;
			end
			rows_fill -= rows_left;
			rows_left = scale;
			if (sr < last) sr++;
		end
		for (int unsigned x = 0; x < w; x++) begin
			a = src_chan(sr, x, 3);
			if (a > 0)
				for (int c = 0; c < 3; c++)
					blend[x][c] = vsum[x][c] + int'(rows_fill) * src_chan(sr, x, c) / 100;
			if (a > blend[x][3]) blend[x][3] = a;
			for (int c = 0; c < 4; c++) vsum[x][c] = 0;
		end
		rows_left -= rows_fill;
		if (rows_left <= 0) begin
			rows_left = scale;
			if (sr < last) sr++;
		end
		rows_fill = 100;
		src_row = sr;

		acc_r = 0; acc_g = 0; acc_b = 0; acc_a = 0;
		for (int unsigned x = 0; x < w; x++) begin
			leftx = scale_reg;
			while (leftx >= fillx) begin
				if (need) begin
					dest++;
					acc_r = 0; acc_g = 0; acc_b = 0; acc_a = 0;
				end
				add_column(x, fillx);
				put_column(dest, nw);
				leftx -= fillx;
				fillx = 100;
				need = 1;
			end
			if (leftx > 0) begin
				if (need) begin
					dest++;
					acc_r = 0; acc_g = 0; acc_b = 0; acc_a = 0;
					need = 0;
				end
				add_column(x, leftx);
				fillx -= leftx;
			end
		end
		if (w > 0 && fillx > 0) add_column(w - 1, fillx);
		if (!need) put_column(dest, nw);
	endtask

	// apply one accepted command word, queue the pixel it returns
	task automatic scale_predict(item_t it);
		result_t r;
		int unsigned w, h, nw, nh;
		logic [31:0] px;
		r = '0;
		case (it.cmd)
			CMD_LOAD: begin
				if (load_ptr < STORE_DEPTH) begin
					frame[load_ptr] = {it.alpha, it.blue, it.green, it.red};
					load_ptr++;
				end
			end
			CMD_RESTART: begin
				load_ptr = 0; src_row = 0; out_row = 0; out_col = 0;
				rows_left = int'(scale_reg);
				rows_fill = 100;
			end
			CMD_FETCH: begin
				w = width_reg;
				h = height_reg;
				nw = w * scale_reg / 100;
				nh = h * scale_reg / 100;
				if (w > MAXW || nw > MAXW || h > MAXH || nh > MAXH) begin
					r.size_error = 1'b1;
				end else if (nw != 0 && nh != 0) begin
					if (out_col >= nw && out_row < nh) begin
						out_col = 0;
						out_row++;
					end
					if (out_row < nh) begin
						if (out_col == 0) build_line(w, h, nw);
						px = out_line[out_col];
						r.out_red = px[7:0];
						r.out_green = px[15:8];
						r.out_blue = px[23:16];
						r.out_alpha = px[31:24];
						r.pixel_valid = 1'b1;
						r.last_pixel = (out_row == nh - 1 && out_col == nw - 1);
						out_col++;
						if (out_col >= nw) begin
							out_col = 0;
							out_row++;
						end
					end
				end
				expected_pixels.push_back(r);
			end
			default: ;
		endcase
	endtask

	// driver: bursts of command words separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) scale_predict(item);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					start <= 1'b0;
					gap_left--;
				end else if (cmd_queue.size() > 0) begin
					item <= cmd_queue.pop_front();
					start <= 1'b1;
					if (burst_left > 0) burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(8, 40);
						else gap_left = $urandom_range(0, 3);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each strobed pixel with the oldest expectation
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel word %h", result);
				errors++;
			end else begin
				e = expected_pixels.pop_front();
				pixels_checked++;
				if (result.out_red !== e.out_red) begin
					$error("out_red exp %0d got %0d", e.out_red, result.out_red);
					errors++;
				end
				if (result.out_green !== e.out_green) begin
					$error("out_green exp %0d got %0d", e.out_green, result.out_green);
					errors++;
				end
				if (result.out_blue !== e.out_blue) begin
					$error("out_blue exp %0d got %0d", e.out_blue, result.out_blue);
					errors++;
				end
				if (result.out_alpha !== e.out_alpha) begin
					$error("out_alpha exp %0d got %0d", e.out_alpha, result.out_alpha);
					errors++;
				end
				if (result.pixel_valid !== e.pixel_valid) begin
					$error("pixel_valid exp %0b got %0b", e.pixel_valid, result.pixel_valid);
					errors++;
				end
				if (result.last_pixel !== e.last_pixel) begin
					$error("last_pixel exp %0b got %0b", e.last_pixel, result.last_pixel);
					errors++;
				end
				if (result.size_error !== e.size_error) begin
					$error("size_error exp %0b got %0b", e.size_error, result.size_error);
					errors++;
				end
			end
		end
	end

	function automatic item_t make_word(logic [1:0] c);
		item_t it;
		it.cmd = c;
		it.red = 8'($urandom);
		it.green = 8'($urandom);
		it.blue = 8'($urandom);
		it.alpha = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		return it;
	endfunction

	task automatic send(logic [1:0] c, int n);
		for (int i = 0; i < n; i++) begin
			cmd_queue.push_back(make_word(c));
			words_sent++;
		end
	endtask

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
		cmd_queue.push_back('{CMD_LOAD, r, g, b, a});
		words_sent++;
	endtask

	// wait until every queued word is taken and every pixel has come back
	task automatic wait_quiet();
		do @(posedge clk);
		while (cmd_queue.size() > 0 || start || expected_pixels.size() > 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_SRC_WIDTH:  width_reg = val & 13'h7F;
			REG_SRC_HEIGHT: height_reg = val & 13'h7F;
			REG_SCALE:      scale_reg = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_size(int unsigned w, int unsigned h, int unsigned sc);
		write_reg(REG_SRC_WIDTH, 13'(w));
		write_reg(REG_SRC_HEIGHT, 13'(h));
		write_reg(REG_SCALE, 13'(sc));
	endtask

	initial begin
		int unsigned w, h, sc, nw, nh, nfetch;
		load_ptr = 0; src_row = 0; out_row = 0; out_col = 0;
		width_reg = RST_SRC_WIDTH;
		height_reg = RST_SRC_HEIGHT;
		scale_reg = RST_SCALE;
		rows_left = int'(RST_SCALE);
		rows_fill = 100;
		for (int x = 0; x < MAXW; x++) begin
			out_line[x] = '0;
			for (int c = 0; c < 4; c++) begin
				vsum[x][c] = 0;
				blend[x][c] = 0;
			end
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// 2x2 at unit scale: transparent, opaque, extreme channel values, ignored code
		set_size(2, 2, 100);
		send(CMD_RESTART, 1);
		send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		send_pixel(8'hFF, 8'h00, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'hFF, 8'h00, 8'h01);
		send_pixel(8'h80, 8'h7F, 8'h01, 8'hFE);
		send(CMD_IGNORED, 1);
		send(CMD_FETCH, 5);
		wait_quiet();
		// zero output size, then oversize results
		write_reg(REG_SCALE, 13'd1);
		send(CMD_FETCH, 2);
		wait_quiet();
		write_reg(REG_SCALE, 13'd6400);
		send(CMD_FETCH, 1);
		wait_quiet();
		set_size(127, 1, 100);
		send(CMD_FETCH, 1);
		wait_quiet();
		images++;

		// largest source, overfilled store, partial readout
		set_size(64, 64, 100);
		send(CMD_RESTART, 1);
		send(CMD_LOAD, STORE_DEPTH + 4);
		send(CMD_FETCH, 130);
		wait_quiet();
		// shrink width mid-image without restart
		write_reg(REG_SRC_WIDTH, 13'd32);
		send(CMD_FETCH, 40);
		wait_quiet();
		// 1x1 blown up to the maximum size
		set_size(1, 1, 6400);
		send(CMD_RESTART, 1);
		send(CMD_LOAD, 1);
		send(CMD_FETCH, 70);
		wait_quiet();
		images += 2;

		// random images, small sizes, mixed scales
		while (words_sent < 1400 + STORE_DEPTH + 250) begin
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 6);
			case ($urandom_range(0, 9))
				0: sc = $urandom_range(1, 60);
				1: sc = $urandom_range(1000, 6400);
				default: sc = $urandom_range(40, 300);
			endcase
			set_size(w, h, sc);
			nw = w * sc / 100;
			nh = h * sc / 100;
			send(CMD_RESTART, 1);
			for (int i = 0; i < int'(w * h); i++) begin
				send(CMD_LOAD, 1);
				if ($urandom_range(0, 15) == 0) send(CMD_IGNORED, 1);
			end
			if (nw > MAXW || nh > MAXH || nw == 0 || nh == 0) nfetch = 3;
			else nfetch = nw * nh + $urandom_range(0, 2);
			if ($urandom_range(0, 11) == 0) nfetch = nfetch / 2 + 1;
			for (int i = 0; i < int'(nfetch); i++) begin
				send(CMD_FETCH, 1);
				case ($urandom_range(0, 29))
					0: send(CMD_LOAD, 1);
					1: send(CMD_IGNORED, 1);
					default: ;
				endcase
			end
			wait_quiet();
			images++;
		end

		repeat (100) @(posedge clk);
		$display("Ran %0d command words over %0d images; %0d result words checked.",
			words_sent, images, pixels_checked);
		if (errors == 0 && expected_pixels.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
